[sv/length_prefixed_chunk_ring_top_assert.svh]
// Assertion macros for the length-prefixed chunk ring.
`ifndef LENGTH_PREFIXED_CHUNK_RING_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_CHUNK_RING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define LPCR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lpcr assertion failed");
// Antecedent at one edge requires the consequent at the next edge.
`define LPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpcr assertion failed");
`else
`define LPCR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/lpcr_pkg.sv]
// Constants and types shared by the length-prefixed chunk ring.
package lpcr_pkg;

	localparam int BUF_BYTES = 1024;
	localparam int RING_AW   = $clog2(BUF_BYTES);
	localparam int PTR_W     = RING_AW + 1;
	localparam int LEN_W     = 10;
	localparam int HDR_BYTES = 4;
	localparam int SUM_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;

	localparam logic [PTR_W-1:0] HDR_STEP = PTR_W'(HDR_BYTES);

	typedef enum logic [1:0] {
		CMD_OPEN  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_DATA        = 3'd0,
		STAT_WRITE_OK    = 3'd1,
		STAT_NO_ROOM     = 3'd2,
		STAT_NOTHING     = 3'd3,
		STAT_ORDER       = 3'd4,
		STAT_EMPTY_CHUNK = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_LEN0,
		S_LEN1,
		S_DATA
	} state_t;

endpackage

[sv/length_prefixed_chunk_ring_top.sv]
// Top level of the length-prefixed chunk ring: one writer, one reader, byte ring memory.
//
// Channel   Direction  Handshake                     Payload
// command   in         start high, busy low          cmd, chunk_len, data_byte
// result    out        result_strobe, one cycle      read_byte, last, status
//
// A rejected command, a data byte write and a read with nothing to read keep busy low.
// An accepted open writes the first header byte at once and the other three in turn
// from the header state on the single memory write port; busy is high meanwhile.
// A read inside a chunk issues the registered memory read and returns the byte from the
// data state; a read that starts a chunk first fetches the two length bytes one at a
// time in the length states, and one that meets an empty chunk ends with no data byte.
// Reset clears ring pointers and flags; the ring memory needs no clearing pass because
// the reader only ever fetches committed bytes. The receiver cannot stall: each result
// is shown for one cycle, and a new command may be taken in that same cycle.
`include "length_prefixed_chunk_ring_top_assert.svh"

module length_prefixed_chunk_ring_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [lpcr_pkg::LEN_W-1:0]    chunk_len,
	input  logic [7:0]                    data_byte,
	output logic                          result_strobe,
	output logic [7:0]                    read_byte,
	output logic                          last,
	output logic [2:0]                    status
);

	localparam int PW = lpcr_pkg::PTR_W;
	localparam int AW = lpcr_pkg::RING_AW;
	localparam int LW = lpcr_pkg::LEN_W;
	localparam int SW = lpcr_pkg::SUM_W;

	// Ring storage: one write port and one read port, read data registered.
	logic [7:0] ring_mem [lpcr_pkg::BUF_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    rdata_q;

	lpcr_pkg::state_t state_q, state_d;

	// Ring pointers run modulo twice the ring size so full and empty differ.
	logic [PW-1:0] write_head_q, write_head_d;
	logic [PW-1:0] write_commit_q, write_commit_d;
	logic [PW-1:0] read_head_q, read_head_d;
	logic [PW-1:0] read_tail_q, read_tail_d;
	logic [LW-1:0] write_rem_q, write_rem_d;
	logic [LW-1:0] read_rem_q, read_rem_d;
	logic          writing_q, writing_d;
	logic          reading_q, reading_d;

	// Header write-out state and the low length byte captured on read.
	logic [PW-1:0] hdr_ptr_q, hdr_ptr_d;
	logic [1:0]    hdr_hi_q, hdr_hi_d;
	logic [1:0]    hdr_cnt_q, hdr_cnt_d;
	logic [7:0]    len_lo_q, len_lo_d;

	// Result register.
	logic               res_load;
	logic [7:0]         res_byte_d, res_byte_q;
	logic               res_last_d, res_last_q;
	lpcr_pkg::status_t  res_stat_d, res_stat_q;
	logic               strobe_q;

	logic              accept;
	lpcr_pkg::cmd_t    cmd_e;
	logic [PW-1:0]     used;
	logic [PW-1:0]     avail;
	logic [SW-1:0]     need_sum;
	logic              fits;
	logic              hdr_ready;
	logic [LW-1:0]     hdr_len;

	assign busy   = (state_q != lpcr_pkg::S_IDLE);
	assign accept = start && !busy;
	assign cmd_e  = lpcr_pkg::cmd_t'(cmd);

	// Bytes in use span from the oldest unfreed chunk to the write head. A chunk fits
	// when its header and payload leave at least one byte free in the ring.
	assign used     = write_head_q - read_tail_q;
	assign need_sum = SW'(chunk_len) + SW'(lpcr_pkg::HDR_BYTES) + SW'(used);
	assign fits     = (need_sum <= SW'(lpcr_pkg::BUF_BYTES - 1));

	// A new chunk can be started only once its whole header is committed.
	assign avail     = write_commit_q - read_head_q;
	assign hdr_ready = (avail >= lpcr_pkg::HDR_STEP);

	// The upper length bits arrive from memory in the second header fetch.
	assign hdr_len = {rdata_q[1:0], len_lo_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpcr_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd_e)
						lpcr_pkg::CMD_OPEN: begin
							if (!writing_q && fits) begin
								state_d = lpcr_pkg::S_HDR;
							end
						end
						lpcr_pkg::CMD_READ: begin
							if (reading_q) begin
								state_d = lpcr_pkg::S_DATA;
							end else if (hdr_ready) begin
								state_d = lpcr_pkg::S_LEN0;
							end
						end
						default: begin
							state_d = lpcr_pkg::S_IDLE;
						end
					endcase
				end
			end
			lpcr_pkg::S_HDR: begin
				if (hdr_cnt_q == 2'd2) begin
					state_d = lpcr_pkg::S_IDLE;
				end
			end
			lpcr_pkg::S_LEN0: begin
				state_d = lpcr_pkg::S_LEN1;
			end
			lpcr_pkg::S_LEN1: begin
				state_d = (hdr_len == '0) ? lpcr_pkg::S_IDLE : lpcr_pkg::S_DATA;
			end
			lpcr_pkg::S_DATA: begin
				state_d = lpcr_pkg::S_IDLE;
			end
			default: begin
				state_d = lpcr_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath, memory control and results.
	always_comb begin
		write_head_d   = write_head_q;
		write_commit_d = write_commit_q;
		read_head_d    = read_head_q;
		read_tail_d    = read_tail_q;
		write_rem_d    = write_rem_q;
		read_rem_d     = read_rem_q;
		writing_d      = writing_q;
		reading_d      = reading_q;
		hdr_ptr_d      = hdr_ptr_q;
		hdr_hi_d       = hdr_hi_q;
		hdr_cnt_d      = hdr_cnt_q;
		len_lo_d       = len_lo_q;
		mem_we         = 1'b0;
		mem_waddr      = write_head_q[AW-1:0];
		mem_wdata      = data_byte;
		mem_re         = 1'b0;
		mem_raddr      = read_head_q[AW-1:0];
		res_load       = 1'b0;
		res_byte_d     = 8'd0;
		res_last_d     = 1'b0;
		res_stat_d     = lpcr_pkg::STAT_ORDER;

		unique case (state_q)
			lpcr_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd_e)
						lpcr_pkg::CMD_OPEN: begin
							res_load = 1'b1;
							if (writing_q) begin
								res_stat_d = lpcr_pkg::STAT_ORDER;
							end else if (!fits) begin
								res_stat_d = lpcr_pkg::STAT_NO_ROOM;
							end else begin
								// Low length byte goes now, the rest of the header follows.
								mem_we       = 1'b1;
								mem_wdata    = chunk_len[7:0];
								hdr_ptr_d    = write_head_q + PW'(1);
								hdr_hi_d     = chunk_len[LW-1:8];
								hdr_cnt_d    = 2'd0;
								write_head_d = write_head_q + lpcr_pkg::HDR_STEP;
								write_rem_d  = chunk_len;
								if (chunk_len == '0) begin
									write_commit_d = write_head_q + lpcr_pkg::HDR_STEP;
								end else begin
									writing_d = 1'b1;
								end
								res_stat_d = lpcr_pkg::STAT_WRITE_OK;
							end
						end
						lpcr_pkg::CMD_WRITE: begin
							res_load = 1'b1;
							if (writing_q) begin
								mem_we       = 1'b1;
								write_head_d = write_head_q + PW'(1);
								write_rem_d  = write_rem_q - LW'(1);
								if (write_rem_q == LW'(1)) begin
									write_commit_d = write_head_q + PW'(1);
									writing_d      = 1'b0;
								end
								res_stat_d = lpcr_pkg::STAT_WRITE_OK;
							end else begin
								res_stat_d = lpcr_pkg::STAT_ORDER;
							end
						end
						lpcr_pkg::CMD_READ: begin
							if (reading_q || hdr_ready) begin
								mem_re = 1'b1;
							end else begin
								res_load   = 1'b1;
								res_stat_d = lpcr_pkg::STAT_NOTHING;
							end
						end
						default: begin
							res_load   = 1'b1;
							res_stat_d = lpcr_pkg::STAT_ORDER;
						end
					endcase
				end
			end
			lpcr_pkg::S_HDR: begin
				mem_we    = 1'b1;
				mem_waddr = hdr_ptr_q[AW-1:0];
				mem_wdata = (hdr_cnt_q == 2'd0) ? {6'd0, hdr_hi_q} : 8'd0;
				hdr_ptr_d = hdr_ptr_q + PW'(1);
				hdr_cnt_d = hdr_cnt_q + 2'd1;
			end
			lpcr_pkg::S_LEN0: begin
				len_lo_d  = rdata_q;
				mem_re    = 1'b1;
				mem_raddr = read_head_q[AW-1:0] + AW'(1);
			end
			lpcr_pkg::S_LEN1: begin
				read_head_d = read_head_q + lpcr_pkg::HDR_STEP;
				if (hdr_len == '0) begin
					read_tail_d = read_head_q + lpcr_pkg::HDR_STEP;
					res_load    = 1'b1;
					res_last_d  = 1'b1;
					res_stat_d  = lpcr_pkg::STAT_EMPTY_CHUNK;
				end else begin
					read_rem_d = hdr_len;
					reading_d  = 1'b1;
					mem_re     = 1'b1;
					mem_raddr  = read_head_q[AW-1:0] + AW'(lpcr_pkg::HDR_BYTES);
				end
			end
			lpcr_pkg::S_DATA: begin
				read_head_d = read_head_q + PW'(1);
				read_rem_d  = read_rem_q - LW'(1);
				res_load    = 1'b1;
				res_byte_d  = rdata_q;
				res_stat_d  = lpcr_pkg::STAT_DATA;
				if (read_rem_q == LW'(1)) begin
					res_last_d  = 1'b1;
					read_tail_d = read_head_q + PW'(1);
					reading_d   = 1'b0;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= ring_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lpcr_pkg::S_IDLE;
			write_head_q   <= '0;
			write_commit_q <= '0;
			read_head_q    <= '0;
			read_tail_q    <= '0;
			write_rem_q    <= '0;
			read_rem_q     <= '0;
			writing_q      <= 1'b0;
			reading_q      <= 1'b0;
			hdr_cnt_q      <= '0;
			strobe_q       <= 1'b0;
		end else begin
			state_q        <= state_d;
			write_head_q   <= write_head_d;
			write_commit_q <= write_commit_d;
			read_head_q    <= read_head_d;
			read_tail_q    <= read_tail_d;
			write_rem_q    <= write_rem_d;
			read_rem_q     <= read_rem_d;
			writing_q      <= writing_d;
			reading_q      <= reading_d;
			hdr_cnt_q      <= hdr_cnt_d;
			strobe_q       <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		hdr_ptr_q <= hdr_ptr_d;
		hdr_hi_q  <= hdr_hi_d;
		len_lo_q  <= len_lo_d;
		if (res_load) begin
			res_byte_q <= res_byte_d;
			res_last_q <= res_last_d;
			res_stat_q <= res_stat_d;
		end
	end

	assign result_strobe = strobe_q;
	assign read_byte     = res_byte_q;
	assign last          = res_last_q;
	assign status        = res_stat_q;

	// An open chunk always has payload bytes still owed.
	`LPCR_ASSERT_ALWAYS(a_writing_rem, clk, arst_n, !writing_q || (write_rem_q != '0))
	// The data fetch stage only runs inside a chunk with bytes left.
	`LPCR_ASSERT_ALWAYS(a_data_in_chunk, clk, arst_n,
		(state_q != lpcr_pkg::S_DATA) || (reading_q && (read_rem_q != '0)))
	// The admission check never lets the ring fill past one byte short of full.
	`LPCR_ASSERT_ALWAYS(a_used_bound, clk, arst_n,
		used <= PW'(lpcr_pkg::BUF_BYTES - 1))
	// Every command other than a read answers in the very next cycle.
	`LPCR_ASSERT_NEXT(a_quick_result, clk, arst_n,
		accept && (cmd_e != lpcr_pkg::CMD_READ), strobe_q)

endmodule

[tb/lpcr_tb_pkg.sv]
// Result type and scoreboard class for the length-prefixed chunk ring testbench.
package lpcr_tb_pkg;
	import lpcr_pkg::*;

	// The one command code that the package does not name.
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       end_mark;
		status_t    st;
	} ring_result_t;

	class ring_scoreboard;
		logic [7:0]       ring_bytes [BUF_BYTES];
		logic [PTR_W-1:0] wr_head, wr_commit, rd_head, rd_tail;
		logic [LEN_W-1:0] wr_left, rd_left;
		bit               wr_open, rd_open;
		ring_result_t     pending[$];
		int unsigned      mismatches, checked;
		int unsigned      status_seen[8];

		function new();
			foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
			wr_head = '0;
			wr_commit = '0;
			rd_head = '0;
			rd_tail = '0;
			wr_left = '0;
			rd_left = '0;
			wr_open = 1'b0;
			rd_open = 1'b0;
			mismatches = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int free_bytes();
			logic [PTR_W-1:0] used;
			used = wr_head - rd_tail;
			if (used > PTR_W'(BUF_BYTES - 1)) return 0;
			return BUF_BYTES - 1 - int'(used);
		endfunction

		// True when a read would return data or an empty chunk.
		function bit readable();
			logic [PTR_W-1:0] avail;
			avail = wr_commit - rd_head;
			return rd_open || (avail >= PTR_W'(HDR_BYTES));
		endfunction

		function int to_ring_end();
			return BUF_BYTES - int'(wr_head[RING_AW-1:0]);
		endfunction

		// Updates the ring image for one accepted item and queues its result.
		function void note_item(logic [1:0] op, logic [LEN_W-1:0] clen, logic [7:0] dbyte);
			ring_result_t     r;
			logic [PTR_W-1:0] p, avail;
			logic [LEN_W-1:0] hlen;
			logic [15:0]      hdr_len;
			bit               go;
			r.byte_out = 8'h00;
			r.end_mark = 1'b0;
			r.st = STAT_ORDER;
			hdr_len = 16'(clen);
			case (op)
				CMD_OPEN: begin
					if (!wr_open) begin
						if (int'(clen) + HDR_BYTES > free_bytes()) begin
							r.st = STAT_NO_ROOM;
						end else begin
							for (int i = 0; i < HDR_BYTES; i++) begin
								p = wr_head + PTR_W'(i);
								ring_bytes[p[RING_AW-1:0]] = (i == 0) ? hdr_len[7:0] :
									(i == 1) ? hdr_len[15:8] : 8'h00;
							end
							wr_head = wr_head + HDR_STEP;
							wr_left = clen;
							if (clen == '0) wr_commit = wr_head;
							else wr_open = 1'b1;
							r.st = STAT_WRITE_OK;
						end
					end
				end
				CMD_WRITE: begin
					if (wr_open) begin
						ring_bytes[wr_head[RING_AW-1:0]] = dbyte;
						wr_head = wr_head + 1'b1;
						wr_left = wr_left - 1'b1;
						if (wr_left == '0) begin
							wr_commit = wr_head;
							wr_open = 1'b0;
						end
						r.st = STAT_WRITE_OK;
					end
				end
				CMD_READ: begin
					go = 1'b1;
					if (!rd_open) begin
						avail = wr_commit - rd_head;
						if (avail < PTR_W'(HDR_BYTES)) begin
							r.st = STAT_NOTHING;
							go = 1'b0;
						end else begin
							p = rd_head + 1'b1;
							hlen = {ring_bytes[p[RING_AW-1:0]][1:0],
								ring_bytes[rd_head[RING_AW-1:0]]};
							rd_head = rd_head + HDR_STEP;
							if (hlen == '0) begin
								rd_tail = rd_head;
								r.st = STAT_EMPTY_CHUNK;
								r.end_mark = 1'b1;
								go = 1'b0;
							end else begin
								rd_left = hlen;
								rd_open = 1'b1;
							end
						end
					end
					if (go) begin
						r.byte_out = ring_bytes[rd_head[RING_AW-1:0]];
						rd_head = rd_head + 1'b1;
						rd_left = rd_left - 1'b1;
						if (rd_left == '0) begin
							r.end_mark = 1'b1;
							rd_tail = rd_head;
							rd_open = 1'b0;
						end
						r.st = STAT_DATA;
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH on result %0d: %s", checked, msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] rb, logic em, logic [2:0] st);
			ring_result_t want;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d", st));
				return;
			end
			want = pending.pop_front();
			status_seen[want.st]++;
			if (st !== want.st)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.st));
			if (rb !== want.byte_out)
				report_mismatch($sformatf("read_byte %0h, expected %0h", rb, want.byte_out));
			if (em !== want.end_mark)
				report_mismatch($sformatf("last %0b, expected %0b", em, want.end_mark));
		endtask
	endclass

endpackage

[tb/tb.sv]
// Testbench for the length-prefixed chunk ring: directed and random commands against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpcr_pkg::*;
	import lpcr_tb_pkg::*;

	// Largest chunk that fits an empty ring: one byte always stays free, four go to the header.
	localparam int MAX_CHUNK = BUF_BYTES - 1 - HDR_BYTES;
	// The full-ring pass packs one data chunk and then this many empty chunks; the data
	// chunk is sized so that the last empty chunk fills the ring to its limit exactly.
	localparam int FILL_EMPTIES = 200;
	localparam int FILL_CHUNK   = MAX_CHUNK - HDR_BYTES * FILL_EMPTIES;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       cmd;
	logic [LEN_W-1:0] chunk_len;
	logic [7:0]       data_byte;
	logic             result_strobe;
	logic [7:0]       read_byte;
	logic             last;
	logic [2:0]       status;

	ring_scoreboard sb;
	int unsigned    items_sent;
	bit             idling_on;

	always #2 clk = ~clk;

	length_prefixed_chunk_ring_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.chunk_len     (chunk_len),
		.data_byte     (data_byte),
		.result_strobe (result_strobe),
		.read_byte     (read_byte),
		.last          (last),
		.status        (status)
	);

	// Results are sampled at the falling edge, in the middle of the single cycle
	// that the strobe is high, so the check never races the rising-edge drivers.
	always @(negedge clk) begin
		if (arst_n && result_strobe === 1'b1)
			sb.check_result(read_byte, last, status);
	end

	// Presents one item and holds it until the block takes it (start high, busy low
	// at a rising edge). Start is left high so back-to-back items need no gap; now
	// and then the sender drops start between items so gaps land on every phase of
	// the multi-cycle opens and chunk-start reads.
	task automatic send_item(logic [1:0] op, logic [LEN_W-1:0] clen, logic [7:0] dbyte);
		start <= 1'b1;
		cmd <= op;
		chunk_len <= clen;
		data_byte <= dbyte;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(op, clen, dbyte);
		items_sent++;
		if (idling_on && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stops sending until every queued result has been seen. It always waits for a
	// clock edge first, so start is never lowered and raised in the same time step.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	// Chunk length for a random open. Most are short; when the write head sits close
	// to the end of the ring, the length is often chosen so that the next header
	// straddles the ring end by one to three bytes.
	function automatic logic [LEN_W-1:0] pick_length();
		int gap, pad, roll;
		gap = sb.to_ring_end();
		pad = $urandom_range(1, 3);
		roll = $urandom_range(0, 99);
		if (roll < 25 && gap <= 60 && gap - pad >= HDR_BYTES)
			return LEN_W'(gap - pad - HDR_BYTES);
		if (roll < 55) return LEN_W'($urandom_range(0, 8));
		if (roll < 85) return LEN_W'($urandom_range(9, 48));
		if (roll < 96) return LEN_W'($urandom_range(49, 250));
		return LEN_W'($urandom_range(0, MAX_CHUNK));
	endfunction

	initial begin
		int roll;
		sb = new();
		items_sent = 0;
		idling_on = 1'b1;
		arst_n = 1'b0;
		start <= 1'b0;
		cmd <= CMD_OPEN;
		chunk_len <= '0;
		data_byte <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a freshly reset ring. Reads and stray data bytes with
		// nothing behind them, the reserved command code, a zero-length chunk, an
		// open that is too large by exactly the header, an open while a chunk is
		// still being written, a read while the only chunk is still uncommitted,
		// then reading back the empty chunk and the data chunks.
		send_item(CMD_READ, 10'h3FF, 8'hFF);
		send_item(CMD_WRITE, 10'd0, 8'hFF);
		send_item(CMD_RESERVED, 10'h3FF, 8'h00);
		send_item(CMD_OPEN, 10'd0, 8'h00);
		send_item(CMD_OPEN, LEN_W'(MAX_CHUNK), 8'h00);
		send_item(CMD_OPEN, 10'd1, 8'h00);
		send_item(CMD_OPEN, 10'd2, 8'h00);
		send_item(CMD_WRITE, 10'd0, 8'h00);
		send_item(CMD_OPEN, 10'd3, 8'h00);
		send_item(CMD_WRITE, 10'd0, 8'hFF);
		send_item(CMD_WRITE, 10'd0, 8'hA5);
		send_item(CMD_WRITE, 10'd0, 8'h5A);
		send_item(CMD_READ, 10'd0, 8'h00);
		send_item(CMD_READ, 10'd0, 8'h00);
		repeat (4) send_item(CMD_READ, 10'd0, 8'h00);
		send_item(CMD_OPEN, 10'd2, 8'h00);
		send_item(CMD_WRITE, 10'd0, 8'h81);
		send_item(CMD_READ, 10'd0, 8'h00);
		send_item(CMD_WRITE, 10'd0, 8'h7E);
		repeat (3) send_item(CMD_READ, 10'd0, 8'h00);
		drain_results();

		// Random part. Mostly well-formed chunks (an open followed by its data bytes)
		// with reads interleaved so the ring fills and drains unevenly, plus a share
		// of out-of-order and reserved commands. One stretch runs with no gaps, and
		// every few hundred items the sender waits for all results to come back.
		for (int unsigned n = 0; n < 950; n++) begin
			idling_on = !(n >= 350 && n < 650);
			if (n % 400 == 399) drain_results();
			roll = $urandom_range(0, 99);
			if (sb.wr_open) begin
				if (roll < 62)
					send_item(CMD_WRITE, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
				else if (roll < 88)
					send_item(CMD_READ, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
				else if (roll < 94)
					send_item(CMD_OPEN, pick_length(), 8'($urandom_range(0, 255)));
				else
					send_item(CMD_RESERVED, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
			end else begin
				if (roll < 42)
					send_item(CMD_OPEN, pick_length(), 8'($urandom_range(0, 255)));
				else if (roll < 88)
					send_item(CMD_READ, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
				else if (roll < 95)
					send_item(CMD_WRITE, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
				else
					send_item(CMD_RESERVED, LEN_W'($urandom_range(0, MAX_CHUNK)),
						8'($urandom_range(0, 255)));
			end
		end
		idling_on = 1'b1;

		// Full-ring pass. Finish any open chunk and read the ring dry, then write one
		// data chunk followed by a run of empty chunks; the headers and data wrap round
		// the ring end wherever the heads happen to be. Halfway through the data, a
		// read must find nothing committed and a second open must be refused as out
		// of order. The last empty chunk fits with no byte to spare, after which the
		// ring holds its maximum and even an empty chunk has no room. Then everything
		// is read back.
		while (sb.wr_open)
			send_item(CMD_WRITE, 10'd0, 8'($urandom_range(0, 255)));
		while (sb.readable())
			send_item(CMD_READ, 10'd0, 8'h00);
		drain_results();
		send_item(CMD_OPEN, LEN_W'(FILL_CHUNK), 8'h00);
		for (int i = 0; i < FILL_CHUNK; i++) begin
			if (i == FILL_CHUNK / 2) begin
				send_item(CMD_READ, 10'd0, 8'h00);
				send_item(CMD_OPEN, 10'd0, 8'h00);
			end
			send_item(CMD_WRITE, 10'd0, 8'($urandom_range(0, 255)));
		end
		repeat (FILL_EMPTIES) send_item(CMD_OPEN, 10'd0, 8'h00);
		send_item(CMD_OPEN, 10'd0, 8'h00);
		while (sb.readable())
			send_item(CMD_READ, 10'd0, 8'h00);
		send_item(CMD_READ, 10'd0, 8'h00);

		// Wait for the last results, then give any stray strobe a chance to show up.
		drain_results();
		repeat (12) @(posedge clk);

		$display("Sent %0d items and checked %0d results; %0d mismatches.",
			items_sent, sb.checked, sb.mismatches);
		$display("Seen: %0d refused for room, %0d out of order, %0d with nothing to read,",
			sb.status_seen[STAT_NO_ROOM], sb.status_seen[STAT_ORDER],
			sb.status_seen[STAT_NOTHING]);
		$display("      %0d empty chunks.", sb.status_seen[STAT_EMPTY_CHUNK]);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// A correct run takes some 1,850 items, under 0.1 ms; this bound is twenty times that.
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
